>>> rtl/core/splat_tile_key_emitter_macros.svh
// Assertion macros shared by the splat tile key emitter checkers.
`ifndef SPLAT_TILE_KEY_EMITTER_MACROS_SVH
`define SPLAT_TILE_KEY_EMITTER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define STKE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define STKE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/stke_pkg.sv
// Shared constants, types and helper functions of the splat tile key emitter.
package stke_pkg;

	localparam int TILE_PIX   = 16;
	localparam int MAX_SPAN   = 8;
	localparam int SUBPIX     = 16;
	localparam int RADIUS_MAX = 880;
	localparam int IMG_MAX    = 4096;
	localparam int W_RESET    = 1920;
	localparam int H_RESET    = 1080;

	localparam int CX_W    = 18;
	localparam int R_W     = 10;
	localparam int DEPTH_W = 32;
	localparam int ID_W    = 24;
	localparam int TI_W    = 16;
	localparam int SIZE_W  = 13;

	localparam int TILE_LOG2 = $clog2(TILE_PIX);
	localparam int SUB_LOG2  = $clog2(SUBPIX);
	localparam int SHIFT     = TILE_LOG2 + SUB_LOG2;

	// Center, radius and rounding need one bit over the center; two are kept.
	localparam int SUM_W  = CX_W + 2;
	localparam int RT_W   = SUM_W - SHIFT;
	localparam int NT_MAX = (IMG_MAX + TILE_PIX - 1) / TILE_PIX;
	localparam int NT_W   = $clog2(NT_MAX + 1);
	localparam int TC_W   = $clog2(NT_MAX);
	localparam int CMP_W  = ((RT_W > NT_W) ? RT_W : NT_W) + 2;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = CFG_IDX_W'(0),
		REG_IMAGE_HEIGHT = CFG_IDX_W'(1)
	} cfg_reg_t;

	// One clamped, non-empty tile box waiting for the emitter.
	typedef struct packed {
		logic [TC_W-1:0]    x0;
		logic [TC_W-1:0]    x1;
		logic [TC_W-1:0]    y0;
		logic [TC_W-1:0]    y1;
		logic [DEPTH_W-1:0] depth;
		logic [ID_W-1:0]    id;
	} run_t;

	// Tiles along one axis: clamp the size to 1..IMG_MAX, then round up.
	function automatic logic [NT_W-1:0] tile_count(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] sc;
		logic [SIZE_W-1:0] sum;
		sc = size;
		if (size == '0) begin
			sc = SIZE_W'(1);
		end else if (size > SIZE_W'(IMG_MAX)) begin
			sc = SIZE_W'(IMG_MAX);
		end
		sum = sc + SIZE_W'(TILE_PIX - 1);
		return NT_W'(sum >> TILE_LOG2);
	endfunction

endpackage

>>> rtl/core/stke_intf.sv
// Request channel interfaces: splat input, key output and register writes.
interface stke_splat_if;
	import stke_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [CX_W-1:0]  center_x;
	logic signed [CX_W-1:0]  center_y;
	logic [R_W-1:0]          radius;
	logic [DEPTH_W-1:0]      depth_word;
	logic [ID_W-1:0]         gaussian_index;

	modport source (output valid, center_x, center_y, radius, depth_word, gaussian_index,
		input ready);
	modport sink (input valid, center_x, center_y, radius, depth_word, gaussian_index,
		output ready);
endinterface

interface stke_key_if;
	import stke_pkg::*;
	logic               valid;
	logic               ready;
	logic [TI_W-1:0]    tile_index;
	logic [DEPTH_W-1:0] depth_key;
	logic [ID_W-1:0]    splat_id;
	logic               last_of_run;

	modport source (output valid, tile_index, depth_key, splat_id, last_of_run, input ready);
	modport sink (input valid, tile_index, depth_key, splat_id, last_of_run, output ready);
endinterface

interface stke_cfg_if;
	import stke_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/splat_tile_key_emitter.sv
// Splat tile key emitter top level: front end, request queue and key emitter.
// A splat goes through the front-end stage, the queue and the box register to the output.
// Throughput: one key per cycle while the output is not stalled, set by the key emitter.
// Splats that cover no tile are dropped in the front end at one per cycle.
// Reset: queue and pipeline empty, output invalid, grid set to a 1920 x 1080 image.
module splat_tile_key_emitter (
	input  logic       clk,
	input  logic       arst_n,
	stke_splat_if.sink splat_in,
	stke_key_if.source key_out,
	stke_cfg_if.sink   cfg
);
	import stke_pkg::*;

	// Front to queue.
	logic            push_valid;
	logic            push_ready;
	run_t            push_data;
	// Queue to emitter.
	logic            pop_valid;
	logic            pop_ready;
	run_t            pop_data;
	// Tiles per row, shared so the emitter can step from row to row.
	logic [NT_W-1:0] ntx;

	// Front end: take register writes and splat requests, turn center and
	// radius into a clamped tile box, drop boxes that cover nothing.
	stke_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.splat_in   (splat_in),
		.cfg        (cfg),
		.ntx        (ntx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Queue: decouple box setup from key emission so each side can stall.
	stke_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Emitter: walk each box y outer, x inner, through a registered output
	// so a new key is prepared in the same cycle the previous one is taken.
	stke_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ntx       (ntx),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.key_out   (key_out)
	);

endmodule

>>> rtl/core/stke_front.sv
// Front end: register writes, splat intake, tile bounds and grid clamping.
module stke_front (
	input  logic                     clk,
	input  logic                     arst_n,
	stke_splat_if.sink               splat_in,
	stke_cfg_if.sink                 cfg,
	output logic [stke_pkg::NT_W-1:0] ntx,
	output logic                     push_valid,
	input  logic                     push_ready,
	output stke_pkg::run_t           push_data
);
	import stke_pkg::*;

	typedef struct packed {
		logic [TC_W-1:0] lo;
		logic [TC_W-1:0] hi;
		logic            empty;
	} axis_t;

	// Clamp one axis to the grid and to the span limit.
	function automatic axis_t clamp_axis(input logic signed [RT_W-1:0] a0,
		input logic signed [RT_W-1:0] a1, input logic [NT_W-1:0] n);
		logic signed [CMP_W-1:0] lo;
		logic signed [CMP_W-1:0] hi;
		logic signed [CMP_W-1:0] lim;
		logic signed [CMP_W-1:0] top;
		axis_t res;
		lo  = CMP_W'(a0);
		hi  = CMP_W'(a1);
		top = signed'(CMP_W'(n)) - CMP_W'(1);
		if (lo < 0) begin
			lo = '0;
		end
		if (hi > top) begin
			hi = top;
		end
		lim = lo + CMP_W'(MAX_SPAN - 1);
		if (hi > lim) begin
			hi = lim;
		end
		res.lo    = TC_W'(lo);
		res.hi    = TC_W'(hi);
		res.empty = (lo > hi);
		return res;
	endfunction

	logic [NT_W-1:0] ntx_q;
	logic [NT_W-1:0] nty_q;

	logic                   v_s1;
	logic signed [RT_W-1:0] x0_s1;
	logic signed [RT_W-1:0] x1_s1;
	logic signed [RT_W-1:0] y0_s1;
	logic signed [RT_W-1:0] y1_s1;
	logic [DEPTH_W-1:0]     depth_s1;
	logic [ID_W-1:0]        id_s1;

	logic [R_W-1:0]          r_sat;
	logic signed [SUM_W-1:0] r_ext;
	logic signed [SUM_W-1:0] cx_ext;
	logic signed [SUM_W-1:0] cy_ext;
	logic signed [SUM_W-1:0] rnd;
	logic                    accept;
	logic                    box_empty;
	axis_t                   ax;
	axis_t                   ay;

	// Register writes land at once.
	assign cfg.ready = 1'b1;
	assign ntx       = ntx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ntx_q <= tile_count(SIZE_W'(W_RESET));
			nty_q <= tile_count(SIZE_W'(H_RESET));
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_IMAGE_WIDTH:  ntx_q <= tile_count(cfg.data);
				REG_IMAGE_HEIGHT: nty_q <= tile_count(cfg.data);
				default: ;
			endcase
		end
	end

	// Saturate the radius, then form both box edges in 1/16 pixel.
	assign r_sat  = (splat_in.radius > R_W'(RADIUS_MAX)) ? R_W'(RADIUS_MAX) : splat_in.radius;
	assign r_ext  = signed'(SUM_W'(r_sat));
	assign cx_ext = SUM_W'(splat_in.center_x);
	assign cy_ext = SUM_W'(splat_in.center_y);
	assign rnd    = signed'(SUM_W'(SUBPIX - 1));

	assign ax = clamp_axis(x0_s1, x1_s1, ntx_q);
	assign ay = clamp_axis(y0_s1, y1_s1, nty_q);
	assign box_empty = ax.empty || ay.empty;

	// Drop empty boxes here; hold the stage while the queue is full.
	assign splat_in.ready = !v_s1 || box_empty || push_ready;
	assign accept         = splat_in.valid && splat_in.ready;

	assign push_valid      = v_s1 && !box_empty;
	assign push_data.x0    = ax.lo;
	assign push_data.x1    = ax.hi;
	assign push_data.y0    = ay.lo;
	assign push_data.y1    = ay.hi;
	assign push_data.depth = depth_s1;
	assign push_data.id    = id_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (splat_in.ready) begin
			v_s1 <= splat_in.valid;
		end
	end

	// Floor of the low edge and ceil of the high edge, then floor by tile size.
	always_ff @(posedge clk) begin
		if (accept) begin
			x0_s1    <= RT_W'((cx_ext - r_ext) >>> SHIFT);
			x1_s1    <= RT_W'((cx_ext + r_ext + rnd) >>> SHIFT);
			y0_s1    <= RT_W'((cy_ext - r_ext) >>> SHIFT);
			y1_s1    <= RT_W'((cy_ext + r_ext + rnd) >>> SHIFT);
			depth_s1 <= splat_in.depth_word;
			id_s1    <= splat_in.gaussian_index;
		end
	end

endmodule

>>> rtl/core/stke_fifo.sv
// Short request queue between the front end and the key emitter.
module stke_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  stke_pkg::run_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output stke_pkg::run_t pop_data
);
	import stke_pkg::*;

	run_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;

	function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	assign push_ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/stke_back.sv
// Key emitter: walks a box row-major, one key per cycle unless stalled.
module stke_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [stke_pkg::NT_W-1:0] ntx,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  stke_pkg::run_t            pop_data,
	stke_key_if.source                key_out
);
	import stke_pkg::*;

	logic                 busy_q;
	run_t                 run_q;
	logic [TC_W-1:0]      x_q;
	logic [TC_W-1:0]      y_q;
	logic [TI_W-1:0]      base_q;
	logic                 out_valid_q;
	logic [TI_W-1:0]      tile_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [ID_W-1:0]      id_q;
	logic                 last_q;

	logic                 out_free;
	logic                 emit;
	logic                 last_key;
	logic                 load;
	logic [TC_W+NT_W-1:0] row_prod;

	assign out_free  = !out_valid_q || key_out.ready;
	assign emit      = busy_q && out_free;
	assign last_key  = (x_q == run_q.x1) && (y_q == run_q.y1);
	// Take the next box in the same cycle as the last key of this one.
	assign pop_ready = !busy_q || (emit && last_key);
	assign load      = pop_valid && pop_ready;
	assign row_prod  = pop_data.y0 * ntx;

	assign key_out.valid       = out_valid_q;
	assign key_out.tile_index  = tile_q;
	assign key_out.depth_key   = depth_q;
	assign key_out.splat_id    = id_q;
	assign key_out.last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && last_key) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (key_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance x inside a row; wrap to the next row and add one row of tiles.
	always_ff @(posedge clk) begin
		if (load) begin
			run_q  <= pop_data;
			x_q    <= pop_data.x0;
			y_q    <= pop_data.y0;
			base_q <= TI_W'(row_prod);
		end else if (emit && !last_key) begin
			if (x_q == run_q.x1) begin
				x_q    <= run_q.x0;
				y_q    <= y_q + TC_W'(1);
				base_q <= base_q + TI_W'(ntx);
			end else begin
				x_q <= x_q + TC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tile_q  <= base_q + TI_W'(x_q);
			depth_q <= run_q.depth;
			id_q    <= run_q.id;
			last_q  <= last_key;
		end
	end

endmodule

>>> rtl/core/splat_tile_key_emitter_chk.sv
// Port-level checker for the splat tile key emitter, bound to the top level.
`include "splat_tile_key_emitter_macros.svh"

module splat_tile_key_emitter_chk (
	input logic        clk,
	input logic        arst_n,
	stke_key_if.source key_out,
	stke_cfg_if.sink   cfg
);

	logic key_stall;
	logic key_more;

	assign key_stall = key_out.valid && !key_out.ready;
	assign key_more  = key_out.valid && key_out.ready && !key_out.last_of_run;

	// A stalled key holds.
	`STKE_ASSERT_NEXT(a_key_hold, clk, arst_n, key_stall, key_out.valid && $stable(key_out.tile_index))

	// Register writes are never stalled.
	`STKE_ASSERT_SAME(a_cfg_ready, clk, arst_n, cfg.valid, cfg.ready)

	// Keys of one splat follow without a gap.
	`STKE_ASSERT_NEXT(a_run_no_gap, clk, arst_n, key_more, key_out.valid)

	// Keys of one splat carry the same splat id and depth.
	`STKE_ASSERT_NEXT(a_run_same_id, clk, arst_n, key_more, $stable(key_out.splat_id))
	`STKE_ASSERT_NEXT(a_run_same_depth, clk, arst_n, key_more, $stable(key_out.depth_key))

endmodule

bind splat_tile_key_emitter splat_tile_key_emitter_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.key_out (key_out),
	.cfg     (cfg)
);

>>> sim/splat_tile_key_emitter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for splat_tile_key_emitter: directed and random splats.
module splat_tile_key_emitter_tb;
	import stke_pkg::*;

	// Quiet cycles with no request moving on any channel before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Splats that cover no tile leave no trace, so after the last owed key is in, hold on
	// while the pipeline flushes them, before a register write and at the end.
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_CYCLES = 20;
	localparam int N_PHASES = 7;
	localparam int RANDOM_PER_PHASE = 11;
	localparam int N_DIRECTED = 21;

	typedef struct packed {
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic [R_W-1:0]         r;
		logic [DEPTH_W-1:0]     depth;
		logic [ID_W-1:0]        id;
	} splat_t;

	typedef struct packed {
		logic [TI_W-1:0]    tile;
		logic [DEPTH_W-1:0] depth;
		logic [ID_W-1:0]    id;
		logic               last;
	} tile_key_t;

	// How a directed row gets its expected keys.
	typedef enum logic [1:0] {
		EXP_PREDICT,
		EXP_NO_KEYS,
		EXP_ONE_KEY
	} exp_kind_t;

	typedef struct packed {
		splat_t          s;
		exp_kind_t       how;
		logic [TI_W-1:0] tile;
	} dir_row_t;

	// Directed splats, all under the reset grid of 120 x 68 tiles (1920 x 1080).
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// origin pixel, all-zero payload
		'{'{18'sd0, 18'sd0, 10'd0, 32'h0000_0000, 24'h00_0000}, EXP_ONE_KEY, 16'd0},
		// last pixel of the image, all-ones payload
		'{'{18'sd30704, 18'sd17264, 10'd0, 32'hFFFF_FFFF, 24'hFF_FFFF}, EXP_ONE_KEY, 16'd8159},
		// most negative column and row (18'sh20000): wholly left, wholly above
		'{'{18'sh20000, 18'sd0, 10'd0, 32'h0000_0001, 24'h00_0001}, EXP_NO_KEYS, 16'd0},
		'{'{18'sd0, 18'sh20000, 10'd0, 32'h0000_0002, 24'h00_0002}, EXP_NO_KEYS, 16'd0},
		// most positive column and row: far right, far below
		'{'{18'sd131071, 18'sd0, 10'd0, 32'h0000_0003, 24'h00_0003}, EXP_NO_KEYS, 16'd0},
		'{'{18'sd0, 18'sd131071, 10'd0, 32'h0000_0004, 24'h00_0004}, EXP_NO_KEYS, 16'd0},
		// one pixel left of the image: floor division must leave it empty
		'{'{-18'sd16, 18'sd800, 10'd0, 32'h0000_0005, 24'h00_0005}, EXP_NO_KEYS, 16'd0},
		// a sixteenth left of the edge still rounds up into column 0
		'{'{-18'sd1, 18'sd0, 10'd0, 32'h0000_0006, 24'h00_0006}, EXP_ONE_KEY, 16'd0},
		// first pixel past the right edge
		'{'{18'sd30720, 18'sd0, 10'd0, 32'h0000_0007, 24'h00_0007}, EXP_NO_KEYS, 16'd0},
		// bottom row of tiles is only partly covered by the image
		'{'{18'sd0, 18'sd17280, 10'd0, 32'h0000_0008, 24'h00_0008}, EXP_ONE_KEY, 16'd8040},
		// below the last tile row
		'{'{18'sd0, 18'sd17408, 10'd0, 32'h0000_0009, 24'h00_0009}, EXP_NO_KEYS, 16'd0},
		// off the left edge by one pixel more than the full radius
		'{'{-18'sd896, 18'sd1600, 10'd880, 32'h0000_000A, 24'h00_000A}, EXP_NO_KEYS, 16'd0},
		// radius just grazes column 0
		'{'{-18'sd881, 18'sd1600, 10'd880, 32'h1234_5678, 24'h12_3456}, EXP_PREDICT, 16'd0},
		// largest radius, then a radius above range that must saturate
		'{'{18'sd1600, 18'sd1600, 10'd880, 32'h3F80_0000, 24'h00_0100}, EXP_PREDICT, 16'd0},
		'{'{18'sd1600, 18'sd1600, 10'd1023, 32'h4000_0000, 24'h00_0101}, EXP_PREDICT, 16'd0},
		// box aligned to tile edges: full 8 x 8 run
		'{'{18'sd16384, 18'sd16384, 10'd880, 32'h4120_0000, 24'h80_0000}, EXP_PREDICT, 16'd0},
		// big boxes clipped by the grid corners and right edge
		'{'{18'sd0, 18'sd0, 10'd880, 32'h7F7F_FFFF, 24'h7F_FFFF}, EXP_PREDICT, 16'd0},
		'{'{18'sd30704, 18'sd17264, 10'd1023, 32'h8000_0000, 24'h00_FFFF}, EXP_PREDICT, 16'd0},
		'{'{18'sd30704, 18'sd8000, 10'd880, 32'hC2C8_0000, 24'hFF_0000}, EXP_PREDICT, 16'd0},
		// alternating bit patterns in the payload
		'{'{18'sd5000, 18'sd3000, 10'd512, 32'hAAAA_AAAA, 24'h55_5555}, EXP_PREDICT, 16'd0},
		'{'{18'sd3000, 18'sd5000, 10'd341, 32'h5555_5555, 24'hAA_AAAA}, EXP_PREDICT, 16'd0}
	};

	// Image sizes per phase; phase 0 keeps the reset size, the last phase draws one at random.
	localparam logic [SIZE_W-1:0] PHASE_WIDTH [N_PHASES] = '{
		13'd1920, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd17, 13'd1920
	};
	localparam logic [SIZE_W-1:0] PHASE_HEIGHT [N_PHASES] = '{
		13'd1080, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4095, 13'd1080
	};

	logic clk;
	logic arst_n;

	stke_splat_if splat_ch ();
	stke_key_if   key_ch ();
	stke_cfg_if   cfg_ch ();

	splat_tile_key_emitter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.splat_in (splat_ch),
		.key_out  (key_ch),
		.cfg      (cfg_ch)
	);

	// Keys still owed by the block, oldest first.
	tile_key_t pending_keys [$];

	// Our copy of the image size registers, raw as written.
	logic [SIZE_W-1:0] image_w_reg;
	logic [SIZE_W-1:0] image_h_reg;

	// Per-phase switches that turn off idling on one side.
	bit send_no_gap;
	bit recv_no_stall;

	int n_splats;
	int n_keys;
	int n_errors;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int floor_div(input int a, input int b);
		int q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q--;
		end
		return q;
	endfunction

	// Size as the block uses it: zero reads as one, anything past the maximum as the maximum.
	function automatic int clamp_image(input logic [SIZE_W-1:0] size);
		if (size == '0) begin
			return 1;
		end
		if (size > IMG_MAX) begin
			return IMG_MAX;
		end
		return int'(size);
	endfunction

	function automatic int grid_tiles(input logic [SIZE_W-1:0] size);
		return (clamp_image(size) + TILE_PIX - 1) / TILE_PIX;
	endfunction

	// Work out the keys one splat must produce and queue them in emission order.
	function automatic void bin_splat(input splat_t s);
		int cx;
		int cy;
		int r;
		int tiles_x;
		int tiles_y;
		int x0;
		int x1;
		int y0;
		int y1;
		tile_key_t k;
		cx = $signed(s.cx);
		cy = $signed(s.cy);
		r = int'(s.r);
		if (r > RADIUS_MAX) begin
			r = RADIUS_MAX;
		end
		tiles_x = grid_tiles(image_w_reg);
		tiles_y = grid_tiles(image_h_reg);
		// floor of the low edge and ceiling of the high edge in pixels, then floor to tiles
		x0 = floor_div(floor_div(cx - r, SUBPIX), TILE_PIX);
		x1 = floor_div(-floor_div(-(cx + r), SUBPIX), TILE_PIX);
		y0 = floor_div(floor_div(cy - r, SUBPIX), TILE_PIX);
		y1 = floor_div(-floor_div(-(cy + r), SUBPIX), TILE_PIX);
		if (x0 < 0) x0 = 0;
		if (y0 < 0) y0 = 0;
		if (x1 > tiles_x - 1) x1 = tiles_x - 1;
		if (y1 > tiles_y - 1) y1 = tiles_y - 1;
		if (x1 > x0 + MAX_SPAN - 1) x1 = x0 + MAX_SPAN - 1;
		if (y1 > y0 + MAX_SPAN - 1) y1 = y0 + MAX_SPAN - 1;
		if (x0 > x1 || y0 > y1) begin
			return;
		end
		for (int y = y0; y <= y1; y++) begin
			for (int x = x0; x <= x1; x++) begin
				k.tile = TI_W'(y * tiles_x + x);
				k.depth = s.depth;
				k.id = s.id;
				k.last = (y == y1 && x == x1);
				pending_keys = {pending_keys, k};
			end
		end
	endfunction

	// Most centers land near the image so boxes hit edges and the interior; a quarter roam
	// the whole signed range. Radii mostly span the legal range, some saturate, some stay tiny.
	function automatic splat_t random_splat();
		splat_t s;
		int pw;
		int ph;
		int pick;
		pw = clamp_image(image_w_reg);
		ph = clamp_image(image_h_reg);
		if ($urandom_range(0, 3) == 0) begin
			s.cx = CX_W'($urandom);
		end else begin
			s.cx = CX_W'(int'($urandom_range(0, (pw + 120) * SUBPIX)) - 60 * SUBPIX);
		end
		if ($urandom_range(0, 3) == 0) begin
			s.cy = CX_W'($urandom);
		end else begin
			s.cy = CX_W'(int'($urandom_range(0, (ph + 120) * SUBPIX)) - 60 * SUBPIX);
		end
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			s.r = R_W'($urandom_range(0, RADIUS_MAX));
		end else if (pick < 17) begin
			s.r = R_W'($urandom_range(RADIUS_MAX + 1, 1023));
		end else begin
			s.r = R_W'($urandom_range(0, 15));
		end
		s.depth = $urandom;
		s.id = ID_W'($urandom);
		return s;
	endfunction

	// Offer one splat after a random gap; return at the edge that accepts it.
	// Valid stays high on return so back-to-back splats need no extra edge.
	task automatic send_splat(input splat_t s);
		int gap;
		gap = send_no_gap ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			splat_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		splat_ch.valid          <= 1'b1;
		splat_ch.center_x       <= s.cx;
		splat_ch.center_y       <= s.cy;
		splat_ch.radius         <= s.r;
		splat_ch.depth_word     <= s.depth;
		splat_ch.gaussian_index <= s.id;
		do @(posedge clk); while (splat_ch.ready !== 1'b1);
		n_splats++;
	endtask

	// Write both size registers back to back, tracking each at its own accept edge.
	task automatic write_image_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_IMAGE_WIDTH;
		cfg_ch.data  <= w;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		image_w_reg = w;
		cfg_ch.index <= REG_IMAGE_HEIGHT;
		cfg_ch.data  <= h;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		image_h_reg = h;
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold until every owed key is in, then let the pipeline flush silent splats.
	task automatic settle(input int cycles);
		wait (pending_keys.size() == 0);
		repeat (cycles) @(posedge clk);
	endtask

	// Stimulus: reset, directed rows under the reset grid, then random splats per image size.
	initial begin : stimulus
		splat_t s;
		dir_row_t row;
		tile_key_t k;
		arst_n = 1'b0;
		splat_ch.valid = 1'b0;
		splat_ch.center_x = '0;
		splat_ch.center_y = '0;
		splat_ch.radius = '0;
		splat_ch.depth_word = '0;
		splat_ch.gaussian_index = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		image_w_reg = 13'(W_RESET);
		image_h_reg = 13'(H_RESET);
		send_no_gap = 1'b0;
		recv_no_stall = 1'b0;
		n_splats = 0;
		n_keys = 0;
		n_errors = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < N_PHASES; p++) begin
			// Roughly one phase in three runs a side flat out.
			send_no_gap = ($urandom_range(0, 2) == 0);
			recv_no_stall = ($urandom_range(0, 2) == 0);
			if (p > 0) begin
				// Drop valid and let the block drain before touching the grid size.
				splat_ch.valid <= 1'b0;
				settle(SETTLE_CYCLES);
				if (p == N_PHASES - 1) begin
					write_image_size(13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)));
				end else begin
					write_image_size(PHASE_WIDTH[p], PHASE_HEIGHT[p]);
				end
			end
			if (p == 0) begin
				for (int i = 0; i < N_DIRECTED; i++) begin
					row = DIRECTED[i];
					send_splat(row.s);
					case (row.how)
						EXP_ONE_KEY: begin
							k.tile = row.tile;
							k.depth = row.s.depth;
							k.id = row.s.id;
							k.last = 1'b1;
							pending_keys = {pending_keys, k};
						end
						EXP_NO_KEYS: begin
						end
						default: begin
							bin_splat(row.s);
						end
					endcase
				end
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				s = random_splat();
				send_splat(s);
				bin_splat(s);
			end
		end

		splat_ch.valid <= 1'b0;
		settle(DRAIN_CYCLES);
		$display("Ran %0d splats over %0d image sizes (reset size, extremes, out-of-range, random)",
			n_splats, N_PHASES);
		$display("Checked %0d keys, %0d mismatches", n_keys, n_errors);
		if (n_errors == 0) begin
			$display("splat_tile_key_emitter_tb: PASS");
		end else begin
			$display("splat_tile_key_emitter_tb: FAIL");
		end
		$finish;
	end

	// Key sink: stall a random number of cycles per key, then compare with the oldest owed key.
	initial begin : key_sink
		int stall;
		tile_key_t want;
		key_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_no_stall ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				key_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			key_ch.ready <= 1'b1;
			do @(posedge clk); while (!(key_ch.valid === 1'b1 && key_ch.ready === 1'b1));
			n_keys++;
			if (pending_keys.size() == 0) begin
				$error("unexpected key: tile_index %0d splat_id %0d", key_ch.tile_index,
					key_ch.splat_id);
				n_errors++;
			end else begin
				want = pending_keys.pop_front();
				if (key_ch.tile_index !== want.tile) begin
					$error("tile_index: expected %0d, got %0d", want.tile, key_ch.tile_index);
					n_errors++;
				end
				if (key_ch.depth_key !== want.depth) begin
					$error("depth_key: expected %h, got %h", want.depth, key_ch.depth_key);
					n_errors++;
				end
				if (key_ch.splat_id !== want.id) begin
					$error("splat_id: expected %0d, got %0d", want.id, key_ch.splat_id);
					n_errors++;
				end
				if (key_ch.last_of_run !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, key_ch.last_of_run);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: end the run if no request moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((splat_ch.valid === 1'b1 && splat_ch.ready === 1'b1) ||
				(key_ch.valid === 1'b1 && key_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= IDLE_LIMIT) begin
				$error("no request moved for %0d cycles, %0d keys still owed", quiet,
					pending_keys.size());
				$display("splat_tile_key_emitter_tb: FAIL");
				$finish;
			end
		end
	end

endmodule
